FILE: sv/erm_pkg.sv
package erm_pkg;

	// angle and result formats
	localparam int ANGLE_FRAC_BITS = 4;
	localparam int OUT_FRAC_BITS   = 14;
	localparam int ANG_W           = 13;
	localparam int OUT_W           = 16;
	localparam int PROD_W          = 2 * OUT_W;

	localparam int FULL_TURN    = 360 << ANGLE_FRAC_BITS;
	localparam int HALF_TURN    = 180 << ANGLE_FRAC_BITS;
	localparam int QUARTER_TURN = 90 << ANGLE_FRAC_BITS;
	localparam int RED_MAX      = QUARTER_TURN / 2;
	localparam int ROM_DEPTH    = RED_MAX + 1;
	localparam int RED_W        = $clog2(ROM_DEPTH);
	localparam int REM_W        = $clog2(QUARTER_TURN);
	localparam int VAL_W        = OUT_FRAC_BITS + 1;
	localparam int OUT_ONE      = 1 << OUT_FRAC_BITS;
	localparam int RED_SHIFT    = 30 - OUT_FRAC_BITS;

	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
	localparam logic [63:0] PI_Q30  = 64'd3373259426;

	typedef logic [ANG_W-1:0]          angle_t;
	typedef logic [RED_W-1:0]          red_t;
	typedef logic [REM_W-1:0]          rem_t;
	typedef logic [1:0]                quad_t;
	typedef logic [VAL_W-1:0]          val_t;
	typedef logic [2*VAL_W-1:0]        sc_word_t;
	typedef sc_word_t                  sc_rom_t [ROM_DEPTH];
	typedef logic signed [OUT_W-1:0]   trig_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [OUT_W:0]     sum_t;

	// load enables of the eight pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
		logic s8;
	} ld_t;

	typedef struct packed {
		trig_t r0c0;
		trig_t r0c1;
		trig_t r0c2;
		trig_t r1c0;
		trig_t r1c1;
		trig_t r1c2;
		trig_t r2c0;
		trig_t r2c1;
		trig_t r2c2;
	} mat_t;

	// taylor series in q2.30, truncating, horner form
	function automatic logic [63:0] sin_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		x2 = (x * x) >> 30;
		t  = ONE_Q30;
		t  = ONE_Q30 - (((x2 * t) >> 30) / 156);
		t  = ONE_Q30 - (((x2 * t) >> 30) / 110);
		t  = ONE_Q30 - (((x2 * t) >> 30) / 72);
		t  = ONE_Q30 - (((x2 * t) >> 30) / 42);
		t  = ONE_Q30 - (((x2 * t) >> 30) / 20);
		t  = ONE_Q30 - (((x2 * t) >> 30) / 6);
		return (x * t) >> 30;
	endfunction

	function automatic logic [63:0] cos_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		x2 = (x * x) >> 30;
		t  = ONE_Q30;
		t  = ONE_Q30 - (((x2 * t) >> 30) / 182);
		t  = ONE_Q30 - (((x2 * t) >> 30) / 132);
		t  = ONE_Q30 - (((x2 * t) >> 30) / 90);
		t  = ONE_Q30 - (((x2 * t) >> 30) / 56);
		t  = ONE_Q30 - (((x2 * t) >> 30) / 30);
		t  = ONE_Q30 - (((x2 * t) >> 30) / 12);
		t  = ONE_Q30 - (((x2 * t) >> 30) / 2);
		return t;
	endfunction

	function automatic val_t to_out(input logic [63:0] v);
		logic [63:0] r;
		r = (v + (64'd1 << (RED_SHIFT - 1))) >> RED_SHIFT;
		return r[VAL_W-1:0];
	endfunction

	// sine and cosine of the first octant, evaluated at elaboration
	function automatic sc_rom_t build_rom();
		sc_rom_t     rom;
		logic [63:0] x;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			x = (64'(i) * PI_Q30 + 64'(HALF_TURN / 2)) / 64'(HALF_TURN);
			rom[i] = {to_out(sin_q30(x)), to_out(cos_q30(x))};
		end
		return rom;
	endfunction

	// round to OUT_FRAC_BITS, half away from zero
	function automatic trig_t fmul_rnd(input prod_t p);
		logic        neg;
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] m;
		neg = p[PROD_W-1];
		mag = neg ? PROD_W'(-p) : PROD_W'(p);
		m   = (mag + PROD_W'(OUT_ONE / 2)) >> OUT_FRAC_BITS;
		return neg ? -trig_t'(m[OUT_W-1:0]) : trig_t'(m[OUT_W-1:0]);
	endfunction

	function automatic trig_t sat_one(input sum_t v);
		if (v > sum_t'(OUT_ONE))
			return trig_t'(OUT_ONE);
		else if (v < -sum_t'(OUT_ONE))
			return -trig_t'(OUT_ONE);
		else
			return v[OUT_W-1:0];
	endfunction

endpackage

FILE: sv/erm_if.sv
interface erm_in_if;
	logic               valid;
	logic               ready;
	erm_pkg::angle_t    angle_x;
	erm_pkg::angle_t    angle_y;
	erm_pkg::angle_t    angle_z;

	modport source(output valid, output angle_x, output angle_y, output angle_z, input ready);
	modport sink(input valid, input angle_x, input angle_y, input angle_z, output ready);
endinterface

interface erm_out_if;
	logic               valid;
	logic               ready;
	erm_pkg::trig_t     m_r0c0;
	erm_pkg::trig_t     m_r0c1;
	erm_pkg::trig_t     m_r0c2;
	erm_pkg::trig_t     m_r1c0;
	erm_pkg::trig_t     m_r1c1;
	erm_pkg::trig_t     m_r1c2;
	erm_pkg::trig_t     m_r2c0;
	erm_pkg::trig_t     m_r2c1;
	erm_pkg::trig_t     m_r2c2;

	modport source(output valid, output m_r0c0, output m_r0c1, output m_r0c2,
		output m_r1c0, output m_r1c1, output m_r1c2,
		output m_r2c0, output m_r2c1, output m_r2c2, input ready);
	modport sink(input valid, input m_r0c0, input m_r0c1, input m_r0c2,
		input m_r1c0, input m_r1c1, input m_r1c2,
		input m_r2c0, input m_r2c1, input m_r2c2, output ready);
endinterface

FILE: sv/erm_cell.sv
module erm_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_ready,
	output logic valid,
	input  logic dn_ready,
	output logic load
);
	logic valid_q;

	// a stage takes new data when empty or when its data moves on
	assign up_ready = !valid_q || dn_ready;
	assign load     = up_valid && up_ready;
	assign valid    = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end
endmodule

FILE: sv/erm_sincos.sv
module erm_sincos (
	input  logic            clk,
	input  erm_pkg::ld_t    ld,
	input  erm_pkg::angle_t angle,
	output erm_pkg::trig_t  sin_val,
	output erm_pkg::trig_t  cos_val
);
	import erm_pkg::*;

	localparam sc_rom_t SC_ROM = build_rom();

	angle_t   a_wrap;
	quad_t    quad;
	rem_t     rem;
	logic     swap;
	red_t     red;
	trig_t    s_raw;
	trig_t    c_raw;
	trig_t    s_sw;
	trig_t    c_sw;

	red_t     red_s1;
	logic     swap_s1;
	quad_t    quad_s1;
	sc_word_t rom_s2;
	logic     swap_s2;
	quad_t    quad_s2;
	trig_t    sin_s3;
	trig_t    cos_s3;

	// wrap into one turn, then split into quadrant and remainder
	always_comb begin
		a_wrap = (angle >= angle_t'(FULL_TURN)) ? angle - angle_t'(FULL_TURN) : angle;
		if (a_wrap >= angle_t'(3 * QUARTER_TURN)) begin
			quad = 2'd3;
			rem  = rem_t'(a_wrap - angle_t'(3 * QUARTER_TURN));
		end else if (a_wrap >= angle_t'(2 * QUARTER_TURN)) begin
			quad = 2'd2;
			rem  = rem_t'(a_wrap - angle_t'(2 * QUARTER_TURN));
		end else if (a_wrap >= angle_t'(QUARTER_TURN)) begin
			quad = 2'd1;
			rem  = rem_t'(a_wrap - angle_t'(QUARTER_TURN));
		end else begin
			quad = 2'd0;
			rem  = rem_t'(a_wrap);
		end
		swap = {1'b0, rem} > (REM_W + 1)'(RED_MAX);
		red  = swap ? red_t'(rem_t'(QUARTER_TURN) - rem) : red_t'(rem);
	end

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			red_s1  <= red;
			swap_s1 <= swap;
			quad_s1 <= quad;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			rom_s2  <= SC_ROM[red_s1];
			swap_s2 <= swap_s1;
			quad_s2 <= quad_s1;
		end
	end

	// undo the octant fold and apply quadrant signs
	always_comb begin
		s_raw = trig_t'(rom_s2[2*VAL_W-1:VAL_W]);
		c_raw = trig_t'(rom_s2[VAL_W-1:0]);
		s_sw  = swap_s2 ? c_raw : s_raw;
		c_sw  = swap_s2 ? s_raw : c_raw;
	end

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			case (quad_s2)
				2'd0: begin
					sin_s3 <= s_sw;
					cos_s3 <= c_sw;
				end
				2'd1: begin
					sin_s3 <= c_sw;
					cos_s3 <= -s_sw;
				end
				2'd2: begin
					sin_s3 <= -s_sw;
					cos_s3 <= -c_sw;
				end
				default: begin
					sin_s3 <= -c_sw;
					cos_s3 <= s_sw;
				end
			endcase
		end
	end

	assign sin_val = sin_s3;
	assign cos_val = cos_s3;
endmodule

FILE: sv/erm_matrix.sv
module erm_matrix (
	input  logic           clk,
	input  erm_pkg::ld_t   ld,
	input  erm_pkg::trig_t sx,
	input  erm_pkg::trig_t cx,
	input  erm_pkg::trig_t sy,
	input  erm_pkg::trig_t cy,
	input  erm_pkg::trig_t sz,
	input  erm_pkg::trig_t cz,
	output erm_pkg::mat_t  mat
);
	import erm_pkg::*;

	// stage 4: raw pair products
	prod_t czsy_s4, szsy_s4, czcy_s4, szcx_s4, szsx_s4;
	prod_t szcy_s4, czcx_s4, czsx_s4, cysx_s4, cycx_s4;
	trig_t sx_s4, cx_s4, sy_s4;
	// stage 5: rounded pair products
	trig_t czsy_s5, szsy_s5, czcy_s5, szcx_s5, szsx_s5;
	trig_t szcy_s5, czcx_s5, czsx_s5, cysx_s5, cycx_s5;
	trig_t sx_s5, cx_s5, sy_s5;
	// stage 6: raw triple products
	prod_t t1_s6, t2_s6, t3_s6, t4_s6;
	trig_t czcy_s6, szcx_s6, szsx_s6, szcy_s6, czcx_s6, czsx_s6, cysx_s6, cycx_s6, sy_s6;
	// stage 7: rounded triple products
	trig_t t1_s7, t2_s7, t3_s7, t4_s7;
	trig_t czcy_s7, szcx_s7, szsx_s7, szcy_s7, czcx_s7, czsx_s7, cysx_s7, cycx_s7, sy_s7;
	mat_t  mat_s8;

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			czsy_s4 <= cz * sy;
			szsy_s4 <= sz * sy;
			czcy_s4 <= cz * cy;
			szcx_s4 <= sz * cx;
			szsx_s4 <= sz * sx;
			szcy_s4 <= sz * cy;
			czcx_s4 <= cz * cx;
			czsx_s4 <= cz * sx;
			cysx_s4 <= cy * sx;
			cycx_s4 <= cy * cx;
			sx_s4   <= sx;
			cx_s4   <= cx;
			sy_s4   <= sy;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s5) begin
			czsy_s5 <= fmul_rnd(czsy_s4);
			szsy_s5 <= fmul_rnd(szsy_s4);
			czcy_s5 <= fmul_rnd(czcy_s4);
			szcx_s5 <= fmul_rnd(szcx_s4);
			szsx_s5 <= fmul_rnd(szsx_s4);
			szcy_s5 <= fmul_rnd(szcy_s4);
			czcx_s5 <= fmul_rnd(czcx_s4);
			czsx_s5 <= fmul_rnd(czsx_s4);
			cysx_s5 <= fmul_rnd(cysx_s4);
			cycx_s5 <= fmul_rnd(cycx_s4);
			sx_s5   <= sx_s4;
			cx_s5   <= cx_s4;
			sy_s5   <= sy_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s6) begin
			t1_s6   <= czsy_s5 * sx_s5;
			t2_s6   <= czsy_s5 * cx_s5;
			t3_s6   <= szsy_s5 * sx_s5;
			t4_s6   <= szsy_s5 * cx_s5;
			czcy_s6 <= czcy_s5;
			szcx_s6 <= szcx_s5;
			szsx_s6 <= szsx_s5;
			szcy_s6 <= szcy_s5;
			czcx_s6 <= czcx_s5;
			czsx_s6 <= czsx_s5;
			cysx_s6 <= cysx_s5;
			cycx_s6 <= cycx_s5;
			sy_s6   <= sy_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s7) begin
			t1_s7   <= fmul_rnd(t1_s6);
			t2_s7   <= fmul_rnd(t2_s6);
			t3_s7   <= fmul_rnd(t3_s6);
			t4_s7   <= fmul_rnd(t4_s6);
			czcy_s7 <= czcy_s6;
			szcx_s7 <= szcx_s6;
			szsx_s7 <= szsx_s6;
			szcy_s7 <= szcy_s6;
			czcx_s7 <= czcx_s6;
			czsx_s7 <= czsx_s6;
			cysx_s7 <= cysx_s6;
			cycx_s7 <= cycx_s6;
			sy_s7   <= sy_s6;
		end
	end

	// sums widen by one bit before clamping to plus or minus one
	always_ff @(posedge clk) begin
		if (ld.s8) begin
			mat_s8.r0c0 <= sat_one(sum_t'(czcy_s7));
			mat_s8.r0c1 <= sat_one(sum_t'(szcx_s7) + sum_t'(t1_s7));
			mat_s8.r0c2 <= sat_one(sum_t'(szsx_s7) - sum_t'(t2_s7));
			mat_s8.r1c0 <= sat_one(-sum_t'(szcy_s7));
			mat_s8.r1c1 <= sat_one(sum_t'(czcx_s7) - sum_t'(t3_s7));
			mat_s8.r1c2 <= sat_one(sum_t'(czsx_s7) + sum_t'(t4_s7));
			mat_s8.r2c0 <= sat_one(sum_t'(sy_s7));
			mat_s8.r2c1 <= sat_one(-sum_t'(cysx_s7));
			mat_s8.r2c2 <= sat_one(sum_t'(cycx_s7));
		end
	end

	assign mat = mat_s8;
endmodule

FILE: sv/euler_rotation_matrix.sv
// channel | dir | payload                          | transfer when
// ang     | in  | angle_x, angle_y, angle_z (u13)  | ang.valid && ang.ready
// mat     | out | m_r0c0 .. m_r2c2 (s16, q1.14)    | mat.valid && mat.ready
//
// eight-stage pipeline, one item per cycle sustained while mat.ready stays high; a result
// shows on mat once it has passed through all the pipeline
// stages: wrap/fold, sine-cosine rom read, sign fix, pair products, round,
// triple products, round, sum and clamp
// arst_n clears every stage's valid bit; data registers are not reset
// a stalled output only holds the stages behind it that are full; empty
// stages keep filling, so ang.ready stays high until the whole chain is full
module euler_rotation_matrix (
	input  logic           clk,
	input  logic           arst_n,
	erm_in_if.sink         ang,
	erm_out_if.source      mat
);
	import erm_pkg::*;

	localparam int NSTAGE = 8;

	// per-stage handshake along the chain of cells
	logic [NSTAGE-1:0] stg_valid;
	logic [NSTAGE:0]   stg_ready;
	logic [NSTAGE-1:0] stg_load;
	ld_t               ld;

	trig_t sx, cx, sy, cy, sz, cz;
	mat_t  mat_val;

	genvar i;
	generate
		for (i = 0; i < NSTAGE; i++) begin : g_cell
			erm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.up_valid ((i == 0) ? ang.valid : stg_valid[(i == 0) ? 0 : i - 1]),
				.up_ready (stg_ready[i]),
				.valid    (stg_valid[i]),
				.dn_ready (stg_ready[i+1]),
				.load     (stg_load[i])
			);
		end
	endgenerate

	assign stg_ready[NSTAGE] = mat.ready;
	assign ang.ready         = stg_ready[0];

	// stage 1 is the first cell
	assign ld = '{s1: stg_load[0], s2: stg_load[1], s3: stg_load[2], s4: stg_load[3],
		s5: stg_load[4], s6: stg_load[5], s7: stg_load[6], s8: stg_load[7]};

	// one sine-cosine unit per axis
	erm_sincos u_sc_x (.clk(clk), .ld(ld), .angle(ang.angle_x), .sin_val(sx), .cos_val(cx));
	erm_sincos u_sc_y (.clk(clk), .ld(ld), .angle(ang.angle_y), .sin_val(sy), .cos_val(cy));
	erm_sincos u_sc_z (.clk(clk), .ld(ld), .angle(ang.angle_z), .sin_val(sz), .cos_val(cz));

	erm_matrix u_matrix (
		.clk (clk),
		.ld  (ld),
		.sx  (sx),
		.cx  (cx),
		.sy  (sy),
		.cy  (cy),
		.sz  (sz),
		.cz  (cz),
		.mat (mat_val)
	);

	// the last stage is the output register
	assign mat.valid  = stg_valid[NSTAGE-1];
	assign mat.m_r0c0 = mat_val.r0c0;
	assign mat.m_r0c1 = mat_val.r0c1;
	assign mat.m_r0c2 = mat_val.r0c2;
	assign mat.m_r1c0 = mat_val.r1c0;
	assign mat.m_r1c1 = mat_val.r1c1;
	assign mat.m_r1c2 = mat_val.r1c2;
	assign mat.m_r2c0 = mat_val.r2c0;
	assign mat.m_r2c1 = mat_val.r2c1;
	assign mat.m_r2c2 = mat_val.r2c2;
endmodule

FILE: sv/erm_check.sv
module erm_check (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input erm_pkg::trig_t r0c0,
	input erm_pkg::trig_t r2c0,
	input erm_pkg::trig_t r2c2
);
	import erm_pkg::*;

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// the input side only stalls when a full chain backs up from the output
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with room in the pipeline");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (r2c2 <= trig_t'(OUT_ONE)) && (r2c2 >= -trig_t'(OUT_ONE)))
		else $error("diagonal entry out of range");

	// a held result keeps its payload (r0c0, r2c0 and r2c2 are checked)
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(r0c0) && $stable(r2c0) && $stable(r2c2))
		else $error("result changed while stalled");

	a_unused_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> $past(in_ready))
		else $error("input transfer without ready");
endmodule

bind euler_rotation_matrix erm_check u_erm_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (ang.valid),
	.in_ready  (ang.ready),
	.out_valid (mat.valid),
	.out_ready (mat.ready),
	.r0c0      (mat.m_r0c0),
	.r2c0      (mat.m_r2c0),
	.r2c2      (mat.m_r2c2)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import erm_pkg::*;

	// one expected rotation matrix per accepted angle triple
	typedef struct packed {
		trig_t r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2;
	} rot_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	erm_in_if  ang ();
	erm_out_if mat ();

	euler_rotation_matrix u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.ang    (ang.sink),
		.mat    (mat.source)
	);

	always #5 clk = ~clk;

	rot_t expected_mats[$];
	int   n_errors = 0;
	int   n_results = 0;
	int   idle_cycles = 0;
	bit   sender_gaps = 1'b1;
	bit   sink_gaps = 1'b1;
	bit   sink_hold = 1'b0;

	// ---------------------------------------------------------------
	// predictor: q2.30 taylor series, then q1.14 products
	// ---------------------------------------------------------------
	function automatic logic [63:0] taylor_sin(input logic [63:0] x);
		logic [63:0] x2, t;
		x2 = (x * x) >> 30;
		t  = 64'd1 << 30;
		for (int k = 6; k >= 1; k--)
			t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'((2 * k) * (2 * k + 1)));
		return (x * t) >> 30;
	endfunction

	function automatic logic [63:0] taylor_cos(input logic [63:0] x);
		logic [63:0] x2, t;
		x2 = (x * x) >> 30;
		t  = 64'd1 << 30;
		for (int k = 7; k >= 1; k--)
			t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'((2 * k - 1) * (2 * k)));
		return t;
	endfunction

	function automatic longint q30_to_q14(input logic [63:0] v);
		return longint'((v + (64'd1 << 15)) >> 16);
	endfunction

	// sine and cosine of one angle, with octant fold and quadrant signs
	task automatic angle_sincos(input angle_t angle, output longint s, output longint c);
		longint unsigned a, q, r, red;
		logic [63:0] x;
		longint ts, tc, t;
		bit swap;
		a    = longint'(angle) % 5760;
		q    = a / 1440;
		r    = a % 1440;
		swap = 2 * r > 1440;
		red  = swap ? 1440 - r : r;
		x    = (64'(red) * 64'd3373259426 + 64'd1440) / 64'd2880;
		ts   = q30_to_q14(taylor_sin(x));
		tc   = q30_to_q14(taylor_cos(x));
		if (swap) begin
			t = ts; ts = tc; tc = t;
		end
		case (q[1:0])
			2'd0: begin s = ts;  c = tc;  end
			2'd1: begin s = tc;  c = -ts; end
			2'd2: begin s = -ts; c = -tc; end
			default: begin s = -tc; c = ts; end
		endcase
	endtask

	// q1.14 product, rounded half away from zero
	function automatic longint q14_mul(input longint a, input longint b);
		longint p, m;
		p = a * b;
		m = ((p < 0 ? -p : p) + 8192) >>> 14;
		return p < 0 ? -m : m;
	endfunction

	function automatic trig_t clamp_one(input longint v);
		if (v > 16384)
			return 16'sd16384;
		if (v < -16384)
			return -16'sd16384;
		return trig_t'(v);
	endfunction

	task automatic predict_rotation(input angle_t ax, input angle_t ay, input angle_t az,
			output rot_t m);
		longint sx, cx, sy, cy, sz, cz, czsy, szsy;
		angle_sincos(ax, sx, cx);
		angle_sincos(ay, sy, cy);
		angle_sincos(az, sz, cz);
		czsy   = q14_mul(cz, sy);
		szsy   = q14_mul(sz, sy);
		m.r0c0 = clamp_one(q14_mul(cz, cy));
		m.r0c1 = clamp_one(q14_mul(sz, cx) + q14_mul(czsy, sx));
		m.r0c2 = clamp_one(q14_mul(sz, sx) - q14_mul(czsy, cx));
		m.r1c0 = clamp_one(-q14_mul(sz, cy));
		m.r1c1 = clamp_one(q14_mul(cz, cx) - q14_mul(szsy, sx));
		m.r1c2 = clamp_one(q14_mul(cz, sx) + q14_mul(szsy, cx));
		m.r2c0 = clamp_one(sy);
		m.r2c1 = clamp_one(-q14_mul(cy, sx));
		m.r2c2 = clamp_one(q14_mul(cy, cx));
	endtask

	// ---------------------------------------------------------------
	// sender side
	// ---------------------------------------------------------------
	initial begin
		ang.valid   = 1'b0;
		ang.angle_x = '0;
		ang.angle_y = '0;
		ang.angle_z = '0;
	end

	// offers one triple and waits for its transfer; the prediction is made on acceptance
	task automatic send_angles(input angle_t ax, input angle_t ay, input angle_t az);
		rot_t m;
		int gap;
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			ang.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ang.valid   <= 1'b1;
		ang.angle_x <= ax;
		ang.angle_y <= ay;
		ang.angle_z <= az;
		@(posedge clk);
		while (!ang.ready)
			@(posedge clk);
		predict_rotation(ax, ay, az, m);
		expected_mats.push_back(m);
	endtask

	task automatic release_input();
		ang.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		ang.valid <= 1'b0;
		while (expected_mats.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// receiver side: random stall bursts, or a long hold when asked
	// ---------------------------------------------------------------
	initial begin
		int burst;
		mat.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (sink_hold) begin
				mat.ready <= 1'b0;
				@(posedge clk);
			end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
				burst = $urandom_range(1, 10);
				mat.ready <= 1'b0;
				repeat (burst) @(posedge clk);
			end else begin
				mat.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic report_mismatch(input string what, input trig_t got, input trig_t want);
		$display("mismatch at result %0d: %s got %0d expected %0d",
			n_results, what, got, want);
		n_errors++;
	endtask

	// result checker, field by field against the oldest prediction
	always @(posedge clk) begin
		rot_t want;
		if (arst_n && mat.valid && mat.ready) begin
			if (expected_mats.size() == 0) begin
				$display("unexpected result %0d with nothing pending", n_results);
				n_errors++;
			end else begin
				want = expected_mats.pop_front();
				if (mat.m_r0c0 !== want.r0c0) report_mismatch("m_r0c0", mat.m_r0c0, want.r0c0);
				if (mat.m_r0c1 !== want.r0c1) report_mismatch("m_r0c1", mat.m_r0c1, want.r0c1);
				if (mat.m_r0c2 !== want.r0c2) report_mismatch("m_r0c2", mat.m_r0c2, want.r0c2);
				if (mat.m_r1c0 !== want.r1c0) report_mismatch("m_r1c0", mat.m_r1c0, want.r1c0);
				if (mat.m_r1c1 !== want.r1c1) report_mismatch("m_r1c1", mat.m_r1c1, want.r1c1);
				if (mat.m_r1c2 !== want.r1c2) report_mismatch("m_r1c2", mat.m_r1c2, want.r1c2);
				if (mat.m_r2c0 !== want.r2c0) report_mismatch("m_r2c0", mat.m_r2c0, want.r2c0);
				if (mat.m_r2c1 !== want.r2c1) report_mismatch("m_r2c1", mat.m_r2c1, want.r2c1);
				if (mat.m_r2c2 !== want.r2c2) report_mismatch("m_r2c2", mat.m_r2c2, want.r2c2);
			end
			n_results++;
		end
	end

	// watchdog: cycles without any transfer on either channel, outside reset and sink hold
	always @(posedge clk) begin
		if ((ang.valid && ang.ready) || (mat.valid && mat.ready) || !arst_n || sink_hold)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// zero, quadrant edges, octant fold points, 360 and the 13-bit maximum (wraps)
	task automatic test_directed();
		angle_t pts[12];
		pts = '{13'd0, 13'd1, 13'd720, 13'd721, 13'd1440, 13'd2160, 13'd2880,
			13'd4320, 13'd5759, 13'd5760, 13'd5761, 13'h1FFF};
		foreach (pts[i])
			send_angles(pts[i], pts[(i + 4) % 12], pts[(i + 8) % 12]);
		send_angles(13'h1FFF, 13'h1FFF, 13'h1FFF);
		send_angles(13'd0, 13'd1440, 13'd0);   // gimbal lock, sy = 1
		send_angles(13'd720, 13'd4320, 13'd720); // gimbal lock, sy = -1
		send_angles(13'd2880, 13'd2880, 13'd2880);
		send_angles(13'h0AAA, 13'h1555, 13'h0AAA); // alternating bit patterns
		release_input();
	endtask

	function automatic angle_t random_angle();
		// mostly the nominal range, some values next to quadrant edges, some wrapping values above one turn
		if ($urandom_range(0, 9) == 0)
			return angle_t'($urandom_range(5760, 8191));
		if ($urandom_range(0, 9) == 0)
			return angle_t'(1440 * $urandom_range(0, 4) + $urandom_range(0, 2) - 1);
		return angle_t'($urandom_range(0, 5760));
	endfunction

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++)
			send_angles(random_angle(), random_angle(), random_angle());
		release_input();
	endtask

	// receiver holds off while the sender keeps offering, so ang.ready must drop
	task automatic test_backpressure();
		fork
			begin
				sink_hold = 1'b1;
				repeat (60) @(posedge clk);
				sink_hold = 1'b0;
			end
			begin
				for (int i = 0; i < 30; i++)
					send_angles(random_angle(), random_angle(), random_angle());
			end
		join
		release_input();
	endtask

	// sender waits for all pending results before going on
	task automatic test_drain_pause();
		for (int i = 0; i < 5; i++)
			send_angles(random_angle(), random_angle(), random_angle());
		wait_drained();
		for (int i = 0; i < 5; i++)
			send_angles(random_angle(), random_angle(), random_angle());
		release_input();
	endtask

	// last part runs at full rate on both sides
	task automatic test_full_rate();
		sender_gaps = 1'b0;
		sink_gaps   = 1'b0;
		test_random(100);
	endtask

	initial begin
		int waited;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(400);
		test_backpressure();
		test_drain_pause();
		test_full_rate();
		waited = 0;
		while (expected_mats.size() != 0 && waited < WATCHDOG_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0 && expected_mats.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
